// ----- sv/channel_busy_until_scheduler_macros.svh -----
// Assertion macros shared by the channel busy-until scheduler RTL.
`ifndef CHANNEL_BUSY_UNTIL_SCHEDULER_MACROS_SVH
`define CHANNEL_BUSY_UNTIL_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBUS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBUS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/cbus_pkg.sv -----
// Types and constants of the channel busy-until scheduler.
package cbus_pkg;

   localparam int TIME_W     = 56;
   localparam int CH_W       = 6;
   localparam int CNT_W      = CH_W + 1;
   localparam int SIZE_W     = 32;
   localparam int COST_W     = 32;
   localparam int PROD_W     = SIZE_W + COST_W;
   localparam int FRAC_BITS  = 16;
   localparam int ACTIVE_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   typedef enum logic [MODE_W-1:0] {
      MODE_DISPATCH = 2'd0,
      MODE_FIND     = 2'd1,
      MODE_QUERY    = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAN = 2'd1,
      STATUS_NONE     = 2'd2,
      STATUS_RSVD     = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE     = 2'd0,
      CSR_READ_COST  = 2'd1,
      CSR_WRITE_COST = 2'd2,
      CSR_NONE       = 2'd3
   } csr_index_type;

endpackage

// ----- sv/channel_busy_until_scheduler.sv -----
// Channel busy-until scheduler: per-channel finish times kept in a one-port-read memory.
// Query and bad-channel beats pass S_EVAL and then S_DONE; dispatch adds S_ADD for the write-back;
// find-first-free stays in S_EVAL for each channel scanned (at least 1), one memory read each.
// The next beat is taken only once the sequencer is back in S_IDLE after the response is loaded;
// a stalled response that keeps the output register full holds the beat in S_DONE longer.
// Synchronous active-high reset clears the valid bits (busy times read as zero), active 8, costs 0.
module channel_busy_until_scheduler #(
   parameter int CHAN_COUNT = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cbus_pkg::MODE_W-1:0]        req_mode,
   input  logic [cbus_pkg::CH_W-1:0]          req_channel,
   input  logic                               req_is_write,
   input  logic [cbus_pkg::SIZE_W-1:0]        req_byte_count,
   input  logic [cbus_pkg::TIME_W-1:0]        req_now,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cbus_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cbus_pkg::CH_W-1:0]          rsp_result_channel,
   output logic                               rsp_channel_free,
   output logic [cbus_pkg::TIME_W-1:0]        rsp_result_time,
   // Configuration write port.
   input  logic                               csr_write_enable,
   input  logic [cbus_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbus_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   `include "channel_busy_until_scheduler_macros.svh"

   // Address width of the busy-time memory; at least one bit.
   localparam int AW = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

   // The engine is a small sequencer around the busy-time memory.
   // S_EVAL sees the registered read data of the entry addressed at the previous edge.
   // S_ADD forms the dispatch finish time and writes it back.
   // S_DONE parks the result until the output register can take it.
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EVAL = 4'b0010,
      S_ADD  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [cbus_pkg::ACTIVE_W-1:0] active_ff;
   logic [cbus_pkg::COST_W-1:0]   rcost_ff;
   logic [cbus_pkg::COST_W-1:0]   wcost_ff;

   // Beat context captured at acceptance.
   cbus_pkg::mode_type            mode_ff;
   logic [cbus_pkg::CH_W-1:0]     ch_ff;
   logic [cbus_pkg::TIME_W-1:0]   now_ff;
   logic [cbus_pkg::CNT_W-1:0]    n_ff;
   logic [cbus_pkg::PROD_W-1:0]   product_ff;

   // Working registers.
   logic [cbus_pkg::CNT_W-1:0]    scan_ff, scan_in;
   logic [cbus_pkg::TIME_W-1:0]   start_ff, start_in;
   logic                          free_ff, free_in;

   // Pending result and the output register.
   cbus_pkg::status_type          res_status_ff, res_status_in;
   logic [cbus_pkg::CH_W-1:0]     res_channel_ff, res_channel_in;
   logic                          res_free_ff, res_free_in;
   logic [cbus_pkg::TIME_W-1:0]   res_time_ff, res_time_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cbus_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [cbus_pkg::CH_W-1:0]     rsp_channel_ff;
   logic                          rsp_free_ff;
   logic [cbus_pkg::TIME_W-1:0]   rsp_time_ff;

   // Busy-time memory with per-entry valid bits; an entry never written reads as zero.
   logic [cbus_pkg::TIME_W-1:0]   mem [CHAN_COUNT];
   logic                          valid_ff [CHAN_COUNT];
   logic [cbus_pkg::TIME_W-1:0]   rd_data_ff;
   logic                          rd_valid_ff;
   logic [AW-1:0]                 rd_addr;
   logic                          mem_we;
   logic [cbus_pkg::TIME_W-1:0]   fin;

   logic                          accept;
   logic                          out_free;
   logic                          load_out;
   logic [cbus_pkg::CNT_W-1:0]    live_count;
   logic [cbus_pkg::COST_W-1:0]   cost;
   logic [cbus_pkg::PROD_W-1:0]   product;
   logic [cbus_pkg::TIME_W-1:0]   busy;
   logic                          is_free;
   logic                          bad;
   logic [cbus_pkg::CNT_W-1:0]    scan_nxt;
   logic [cbus_pkg::TIME_W:0]     sum;
   logic                          scan_live;

   // A request beat is taken whenever the sequencer is idle, even while a finished
   // response still waits in the output register.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == S_DONE) && out_free;

   // Effective channel count: active_channels clipped to the number of memory entries.
   assign live_count = ({{(cbus_pkg::CNT_W-cbus_pkg::ACTIVE_W){1'b0}}, active_ff}
                        > cbus_pkg::CNT_W'(CHAN_COUNT))
                       ? cbus_pkg::CNT_W'(CHAN_COUNT)
                       : {{(cbus_pkg::CNT_W-cbus_pkg::ACTIVE_W){1'b0}}, active_ff};

   // Service product, registered before it joins the finish-time add.
   assign cost    = req_is_write ? wcost_ff : rcost_ff;
   assign product = cbus_pkg::PROD_W'(req_byte_count) * cbus_pkg::PROD_W'(cost);

   assign busy     = rd_valid_ff ? rd_data_ff : '0;
   assign is_free  = (busy <= now_ff);
   assign bad      = ({1'b0, ch_ff} >= n_ff);
   assign scan_nxt = scan_ff + 1'b1;

   // Finish time: start plus whole-tick service, saturating at the top of the time range.
   assign sum = {1'b0, start_ff}
              + (cbus_pkg::TIME_W+1)'(product_ff[cbus_pkg::PROD_W-1:cbus_pkg::FRAC_BITS]);
   assign fin = sum[cbus_pkg::TIME_W] ? '1 : sum[cbus_pkg::TIME_W-1:0];

   assign mem_we = (state_ff == S_ADD);

   // Read address: the request's channel (or entry 0 for a scan) at acceptance, and the
   // next scan entry while a find-first-free walks the memory.
   always_comb begin
      if (state_ff == S_IDLE) begin
         rd_addr = (req_mode == cbus_pkg::MODE_FIND) ? '0 : req_channel[AW-1:0];
      end else begin
         rd_addr = scan_nxt[AW-1:0];
      end
   end

   // Sequencer and result formation.
   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      start_in       = start_ff;
      free_in        = free_ff;
      res_status_in  = res_status_ff;
      res_channel_in = res_channel_ff;
      res_free_in    = res_free_ff;
      res_time_in    = res_time_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
               scan_in  = '0;
            end
         end
         S_EVAL: begin
            state_in       = S_DONE;
            res_status_in  = cbus_pkg::STATUS_OK;
            res_channel_in = ch_ff;
            res_free_in    = 1'b0;
            res_time_in    = '0;
            case (mode_ff)
               cbus_pkg::MODE_DISPATCH: begin
                  if (bad) begin
                     res_status_in = cbus_pkg::STATUS_BAD_CHAN;
                  end else begin
                     free_in  = is_free;
                     start_in = is_free ? now_ff : busy;
                     state_in = S_ADD;
                  end
               end
               cbus_pkg::MODE_FIND: begin
                  if ((scan_ff < n_ff) && is_free) begin
                     res_channel_in = scan_ff[cbus_pkg::CH_W-1:0];
                     res_free_in    = 1'b1;
                     res_time_in    = busy;
                  end else if (scan_nxt < n_ff) begin
                     scan_in  = scan_nxt;
                     state_in = S_EVAL;
                  end else begin
                     res_status_in  = cbus_pkg::STATUS_NONE;
                     res_channel_in = '0;
                  end
               end
               cbus_pkg::MODE_QUERY: begin
                  if (bad) begin
                     res_status_in = cbus_pkg::STATUS_BAD_CHAN;
                  end else begin
                     res_free_in = is_free;
                     res_time_in = busy;
                  end
               end
               default: begin
                  res_channel_in = '0;
               end
            endcase
         end
         S_ADD: begin
            // The write lands at this edge; the next beat's read comes only after S_DONE hands
            // the result off, so no forwarding path is needed.
            res_status_in  = cbus_pkg::STATUS_OK;
            res_channel_in = ch_ff;
            res_free_in    = free_ff;
            res_time_in    = fin;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= cbus_pkg::ACTIVE_RESET;
         rcost_ff     <= '0;
         wcost_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               cbus_pkg::CSR_ACTIVE:     active_ff <= csr_write_data[cbus_pkg::ACTIVE_W-1:0];
               cbus_pkg::CSR_READ_COST:  rcost_ff  <= csr_write_data[cbus_pkg::COST_W-1:0];
               cbus_pkg::CSR_WRITE_COST: wcost_ff  <= csr_write_data[cbus_pkg::COST_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Entry valid bits: reset marks every busy time as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAN_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (mem_we) begin
         valid_ff[ch_ff[AW-1:0]] <= 1'b1;
      end
   end

   // Busy-time memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ch_ff[AW-1:0]] <= fin;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= cbus_pkg::mode_type'(req_mode);
         ch_ff      <= req_channel;
         now_ff     <= req_now;
         n_ff       <= live_count;
         product_ff <= product;
      end
      scan_ff        <= scan_in;
      start_ff       <= start_in;
      free_ff        <= free_in;
      res_status_ff  <= res_status_in;
      res_channel_ff <= res_channel_in;
      res_free_ff    <= res_free_in;
      res_time_ff    <= res_time_in;
      if (load_out) begin
         rsp_status_ff  <= res_status_ff;
         rsp_channel_ff <= res_channel_ff;
         rsp_free_ff    <= res_free_ff;
         rsp_time_ff    <= res_time_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_channel = rsp_channel_ff;
   assign rsp_channel_free   = rsp_free_ff;
   assign rsp_result_time    = rsp_time_ff;

   // A find-first-free scan is in progress over a non-empty channel set.
   assign scan_live = (state_ff == S_EVAL) && (mode_ff == cbus_pkg::MODE_FIND) && (n_ff != '0);

   // An accepted beat always reaches the evaluation state next.
   `CBUS_ASSERT_NEXT(a_accept_eval, clock, reset, accept, state_ff == S_EVAL, "eval missed")
   // A write-back is always followed by the result hand-off.
   `CBUS_ASSERT_NEXT(a_add_done, clock, reset, state_ff == S_ADD, state_ff == S_DONE, "no done")
   // Handing the result to a free output register makes it visible and frees the engine.
   `CBUS_ASSERT_NEXT(a_done_out, clock, reset, load_out, rsp_valid_ff && !req_stall, "result lost")
   // A scan never looks at an entry beyond the effective channel count.
   `CBUS_ASSERT_SAME(a_scan_range, clock, reset, scan_live, scan_ff < n_ff, "scan out of range")

endmodule
